@@ sv/assert_macros.svh @@
// Assertion macros shared by the design files.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLY(name, clk, rstn, ante, cons)
`define ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

@@ sv/ss5_pkg.sv @@
`default_nettype none

package ss5_pkg;

    // Default build values.
    localparam int SAMPLE_RATE_HZ_DEF = 8000;
    localparam int PHASE_BITS_DEF     = 16;
    localparam int SINE_ADDR_BITS_DEF = 8;

    // Signal levels.
    localparam int AMP      = 64;
    localparam int MIDLEVEL = 128;

    // Signalling table.
    localparam int N_ENTRIES = 18;
    localparam int IDX_BITS  = $clog2(N_ENTRIES);
    localparam int MAX_MS    = 850;

    localparam logic [7:0] DIGIT_CODE [N_ENTRIES] = '{
        "A", "B", "C", "1", "2", "3", "4", "5", "6",
        "7", "8", "9", "0", "d", "e", "a", "b", "c"
    };
    localparam int FREQ_A [N_ENTRIES] = '{
        2400, 2600, 2400, 700, 700, 900, 700, 900, 1100,
        700, 900, 1100, 1300, 700, 900, 1100, 1300, 1500
    };
    localparam int FREQ_B [N_ENTRIES] = '{
        0, 0, 2600, 900, 1100, 1100, 1300, 1300, 1300,
        1500, 1500, 1500, 1500, 1700, 1700, 1700, 1700, 1700
    };
    localparam int TONE_MS [N_ENTRIES] = '{
        150, 850, 70, 55, 55, 55, 55, 55, 55,
        55, 55, 55, 55, 55, 55, 100, 100, 55
    };
    localparam int GAP_MS [N_ENTRIES] = '{
        100, 100, 100, 50, 50, 50, 50, 50, 50,
        50, 50, 50, 50, 50, 50, 50, 50, 50
    };

    // pi/2 in Q30.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Request outcome reported with each result.
    typedef enum logic [1:0] {
        ST_TICK     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_BUSY     = 2'd3
    } status_t;

    // Sequencer state.
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_TONE  = 3'b010,
        MODE_PAUSE = 3'b100
    } mode_t;

    // Sine table entry: round(64*sin(2*pi*addr/2^addr_bits)), evaluated at
    // elaboration with a Q30 Taylor series so that every entry rounds as the
    // floating-point value does.
    function automatic logic signed [7:0] sine_value(input int unsigned addr,
                                                     input int unsigned addr_bits);
        longint unsigned q;
        longint unsigned quad;
        longint unsigned off;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned mag;
        longint          sum;
        logic signed [7:0] res;
        q    = 64'd1 << (addr_bits - 2);
        quad = (longint'(addr) >> (addr_bits - 2)) & 64'd3;
        off  = longint'(addr) & (q - 64'd1);
        if (quad[0]) begin
            off = q - off;
        end
        x    = (off * HALF_PI_Q30) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        mag = ((longint'(sum) * AMP) + (64'd1 << 29)) >> 30;
        res = 8'(mag);
        if (quad >= 64'd2) begin
            res = -res;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/ss5_sine_rom.sv @@
`default_nettype none

module ss5_sine_rom #(
    parameter int ADDR_BITS = ss5_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic [ADDR_BITS-1:0]        rd_addr,
    output logic signed [7:0]                rd_data
);
    import ss5_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic signed [7:0] rom_tab [DEPTH];
    logic signed [7:0] rd_data_reg;

    // Constant sine table built at elaboration.
    for (genvar a = 0; a < DEPTH; a++) begin : g_rom
        assign rom_tab[a] = sine_value(a, ADDR_BITS);
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= rom_tab[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/ss5_mf_tone_generator.sv @@
// Pipeline: a request accepted into the input register moves on into the result register,
// which drives m_, once that register is empty or being drained by m_tready.
// Throughput: one request per cycle with no stall of its own; the input waits only while
// a result is held back by m_tready. The sine ROM read is prefetched from the next phase.
// Reset (aresetn low at a rising edge) empties both registers, clears both phases,
// the sample counter and the table index, and returns the sequencer to idle.
`default_nettype none

`include "assert_macros.svh"

module ss5_mf_tone_generator #(
    parameter int SAMPLE_RATE_HZ = ss5_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int PHASE_BITS     = ss5_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = ss5_pkg::SINE_ADDR_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] digit_code
    input  wire logic        s_tuser,   // [0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] sample, [8] sample_valid, [9] tone_on,
                                        // [10] busy_res, [15:11] zero
    output logic [1:0]       m_tuser,   // [1:0] request_status
    output logic             m_tlast    // end_of_digit
);
    import ss5_pkg::*;

    localparam longint unsigned MAX_LEN = longint'(MAX_MS) * SAMPLE_RATE_HZ / 1000;
    localparam int CNT_BITS = $clog2(MAX_LEN + 1);

    // Per-entry phase increments and lengths in samples.
    logic [PHASE_BITS-1:0] inc_a_tab [N_ENTRIES];
    logic [PHASE_BITS-1:0] inc_b_tab [N_ENTRIES];
    logic [CNT_BITS-1:0]   tone_len_tab [N_ENTRIES];
    logic [CNT_BITS-1:0]   gap_len_tab [N_ENTRIES];

    for (genvar g = 0; g < N_ENTRIES; g++) begin : g_tab
        localparam longint unsigned INC_A =
            ((longint'(FREQ_A[g]) << PHASE_BITS) + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ;
        localparam longint unsigned INC_B =
            ((longint'(FREQ_B[g]) << PHASE_BITS) + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ;
        localparam longint unsigned TONE_RAW = longint'(TONE_MS[g]) * SAMPLE_RATE_HZ / 1000;
        localparam longint unsigned GAP_RAW  = longint'(GAP_MS[g]) * SAMPLE_RATE_HZ / 1000;
        localparam longint unsigned TONE_LEN = (TONE_RAW == 0) ? 1 : TONE_RAW;
        localparam longint unsigned GAP_LEN  = (GAP_RAW == 0) ? 1 : GAP_RAW;
        assign inc_a_tab[g]    = PHASE_BITS'(INC_A);
        assign inc_b_tab[g]    = PHASE_BITS'(INC_B);
        assign tone_len_tab[g] = CNT_BITS'(TONE_LEN);
        assign gap_len_tab[g]  = CNT_BITS'(GAP_LEN);
    end

    // Input register.
    logic       in_valid_reg;
    logic       in_req_reg;
    logic [7:0] in_code_reg;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] out_sample_reg;
    logic       out_sval_reg;
    logic       out_tone_reg;
    logic       out_eod_reg;
    status_t    out_status_reg;
    logic       out_busy_reg;

    // Generator state.
    mode_t                 mode_reg, mode_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [PHASE_BITS-1:0] ph1_reg, ph1_next;
    logic [PHASE_BITS-1:0] ph2_reg, ph2_next;

    // Result of the current request.
    logic [7:0] res_sample;
    logic       res_sval;
    logic       res_tone;
    logic       res_eod;
    status_t    res_status;

    logic                  advance;
    logic                  proc;
    logic                  busy;
    logic                  hit;
    logic [IDX_BITS-1:0]   hit_idx;
    logic [CNT_BITS-1:0]   cnt_inc;
    logic signed [7:0]     sine1;
    logic signed [7:0]     sine2;
    logic signed [9:0]     mix;
    logic [PHASE_BITS-1:0] ph1_rd;
    logic [PHASE_BITS-1:0] ph2_rd;

    // The result register moves whenever it is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign busy     = (mode_reg == MODE_TONE) || (mode_reg == MODE_PAUSE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg  <= s_tuser;
            in_code_reg <= s_tdata;
        end
    end

    // Digit lookup; the first matching entry wins.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = N_ENTRIES - 1; i >= 0; i--) begin
            if (in_code_reg == DIGIT_CODE[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_BITS'(i);
            end
        end
    end

    // Tone sample: mid level plus both sine values, saturated to eight bits.
    always_comb begin
        mix = 10'sd128 + 10'(sine1) + 10'(sine2);
        if (mix > 10'sd255) begin
            res_sample = 8'hFF;
        end else if (mix < 10'sd0) begin
            res_sample = 8'h00;
        end else begin
            res_sample = mix[7:0];
        end
    end

    // Sequencer next state and result flags.
    always_comb begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        ph1_next   = ph1_reg;
        ph2_next   = ph2_reg;
        res_sval   = 1'b0;
        res_tone   = 1'b0;
        res_eod    = 1'b0;
        res_status = ST_TICK;
        cnt_inc    = cnt_reg + 1'b1;
        if (proc) begin
            if (in_req_reg) begin
                if (busy) begin
                    res_status = ST_BUSY;
                end else if (hit) begin
                    res_status = ST_ACCEPTED;
                    idx_next   = hit_idx;
                    ph1_next   = '0;
                    ph2_next   = '0;
                    cnt_next   = '0;
                    mode_next  = MODE_TONE;
                end else begin
                    res_status = ST_UNKNOWN;
                end
            end else begin
                unique case (mode_reg)
                    MODE_TONE: begin
                        res_sval = 1'b1;
                        res_tone = 1'b1;
                        ph1_next = ph1_reg + inc_a_tab[idx_reg];
                        ph2_next = ph2_reg + inc_b_tab[idx_reg];
                        if (cnt_inc >= tone_len_tab[idx_reg]) begin
                            mode_next = MODE_PAUSE;
                            cnt_next  = '0;
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    MODE_PAUSE: begin
                        res_sval = 1'b1;
                        if (cnt_inc >= gap_len_tab[idx_reg]) begin
                            res_eod   = 1'b1;
                            mode_next = MODE_IDLE;
                            cnt_next  = '0;
                        end else begin
                            cnt_next = cnt_inc;
                        end
                    end
                    default: begin
                        res_sval = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
            idx_reg  <= '0;
            ph1_reg  <= '0;
            ph2_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            ph1_reg  <= ph1_next;
            ph2_reg  <= ph2_next;
        end
    end

    // The ROMs read the phase that the state registers take next, so their
    // output always matches the current phase.
    assign ph1_rd = aresetn ? ph1_next : '0;
    assign ph2_rd = aresetn ? ph2_next : '0;

    ss5_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom_one (
        .aclk    (aclk),
        .rd_addr (ph1_rd[PHASE_BITS-1 -: SINE_ADDR_BITS]),
        .rd_data (sine1)
    );

    ss5_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom_two (
        .aclk    (aclk),
        .rd_addr (ph2_rd[PHASE_BITS-1 -: SINE_ADDR_BITS]),
        .rd_data (sine2)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_sample_reg <= res_tone ? res_sample : 8'(MIDLEVEL);
            out_sval_reg   <= res_sval;
            out_tone_reg   <= res_tone;
            out_eod_reg    <= res_eod;
            out_status_reg <= res_status;
            out_busy_reg   <= (mode_next == MODE_TONE) || (mode_next == MODE_PAUSE);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_busy_reg, out_tone_reg, out_sval_reg, out_sample_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_eod_reg;

    // The last pause sample ends the digit.
    `ASSERT_IMPLY(a_eod_ends_digit, aclk, aresetn, m_tvalid && m_tlast, out_sval_reg && !out_tone_reg && !out_busy_reg)

    // An accepted digit starts running and carries no sample.
    `ASSERT_IMPLY(a_accept_busy, aclk, aresetn, m_tvalid && (out_status_reg == ST_ACCEPTED), out_busy_reg && !out_sval_reg)

    // Starting a digit restarts both phases and the counter.
    `ASSERT_NEXT(a_start_clears, aclk, aresetn, proc && in_req_reg && !busy && hit, (ph1_reg == '0) && (ph2_reg == '0) && (cnt_reg == '0) && (mode_reg == MODE_TONE))

    // A request is refused only while a stalled result blocks the input register.
    `ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_tready)

endmodule

`default_nettype wire
